// ===== rtl/crcf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the CRC-8 length framer: codes, limits, result types and the CRC fold.
// Used by every module of the framer and by the testbench.
package crcf_pkg;

    // Framing constants
    localparam logic [7:0]  START_BYTE = 8'h7E;
    localparam logic [7:0]  CRC_POLY   = 8'h07;
    localparam int          MAX_FRAME  = 1024;
    localparam logic [15:0] MAX_LEN    = 16'(MAX_FRAME);
    localparam int          LEFT_W     = $clog2(MAX_FRAME + 1);

    // Number of result words one input word can cause
    localparam int MAX_RESULTS = 3;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    typedef enum logic
    {
        KIND_START = 1'b0,
        KIND_DATA  = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK       = 2'd0,
        STATUS_BAD_LEN  = 2'd1,
        STATUS_NO_FRAME = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       last_of_run;
        logic [1:0] status;
    } result_t;

    // All result words caused by one input word, first result in word[0]
    typedef struct packed
    {
        logic [COUNT_W-1:0]          count;
        result_t [MAX_RESULTS-1:0]   word;
    } burst_t;

    // One byte folded into the CRC-8, polynomial 0x07, most significant bit first.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/crcf_item_if.sv =====
`timescale 1ns / 1ps
// Input channel of the framer: valid/ready handshake with start and payload fields.
// Depends on nothing but the handshake convention; widths match crcf_pkg.
interface crcf_item_if;

    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_len;

    modport source (output valid, output kind, output data_byte, output frame_len,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_len,
                    output ready);

endinterface

// ===== rtl/crcf_stream_if.sv =====
`timescale 1ns / 1ps
// Output channel of the framer: valid/ready handshake carrying one framed byte a word.
// Depends on nothing but the handshake convention; widths match crcf_pkg.
interface crcf_stream_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       last_of_run;
    logic [1:0] status;

    modport source (output valid, output out_byte, output frame_end, output last_of_run,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input frame_end, input last_of_run,
                    input status, output ready);

endinterface

// ===== rtl/crcf_core.sv =====
`timescale 1ns / 1ps
// Framing state (open flag, bytes left, running CRC) and result generation per input word.
// Depends on crcf_pkg and crcf_item_if.
module crcf_core
(
    input  logic            clk,
    input  logic            rst_n,
    crcf_item_if.sink       item,
    input  logic            can_load,
    output logic            load,
    output crcf_pkg::burst_t burst
);
    import crcf_pkg::*;

    logic              frame_open_reg;
    logic              frame_open_next;
    logic [LEFT_W-1:0] bytes_left_reg;
    logic [LEFT_W-1:0] bytes_left_next;
    logic [7:0]        crc_reg;
    logic [7:0]        crc_next;
    logic [7:0]        crc_fold_val;
    logic [LEFT_W-1:0] left_dec;
    logic              bad_len;

    // A word is taken whenever the result queue can take its results.
    assign item.ready = can_load;
    assign load       = item.valid & item.ready;

    assign crc_fold_val = crc8_fold(crc_reg, item.data_byte);
    assign left_dec     = (bytes_left_reg != '0) ? bytes_left_reg - LEFT_W'(1) : '0;
    assign bad_len      = (item.frame_len == 16'd0) || (item.frame_len > MAX_LEN);

    // Results and next state for the word at the input.
    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        burst           = '0;

        if (item.kind == KIND_START)
        begin
            crc_next = 8'd0;
            if (bad_len)
            begin
                // Rejected length abandons any open frame.
                frame_open_next           = 1'b0;
                bytes_left_next           = '0;
                burst.count               = COUNT_W'(1);
                burst.word[0].last_of_run = 1'b1;
                burst.word[0].status      = STATUS_BAD_LEN;
            end
            else
            begin
                frame_open_next           = 1'b1;
                bytes_left_next           = item.frame_len[LEFT_W-1:0];
                burst.count               = COUNT_W'(3);
                burst.word[0].out_byte    = START_BYTE;
                burst.word[1].out_byte    = item.frame_len[15:8];
                burst.word[2].out_byte    = item.frame_len[7:0];
                burst.word[2].last_of_run = 1'b1;
            end
        end
        else if (!frame_open_reg)
        begin
            // Payload byte with no frame open: report it, leave the state alone.
            burst.count               = COUNT_W'(1);
            burst.word[0].last_of_run = 1'b1;
            burst.word[0].status      = STATUS_NO_FRAME;
        end
        else
        begin
            bytes_left_next        = left_dec;
            burst.word[0].out_byte = item.data_byte;
            if (left_dec == '0)
            begin
                // Final payload byte: follow it with the CRC and close the frame.
                frame_open_next           = 1'b0;
                crc_next                  = 8'd0;
                burst.count               = COUNT_W'(2);
                burst.word[1].out_byte    = crc_fold_val;
                burst.word[1].frame_end   = 1'b1;
                burst.word[1].last_of_run = 1'b1;
            end
            else
            begin
                crc_next                  = crc_fold_val;
                burst.count               = COUNT_W'(1);
                burst.word[0].last_of_run = 1'b1;
            end
        end
    end

    // State registers, updated only when a word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= '0;
            crc_reg        <= 8'd0;
        end
        else if (load)
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

// ===== rtl/crcf_out_queue.sv =====
`timescale 1ns / 1ps
// Result register bank: up to three result words, shifted out one a cycle when ready.
// Depends on crcf_pkg and crcf_stream_if.
module crcf_out_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  crcf_pkg::burst_t burst,
    output logic             can_load,
    crcf_stream_if.source    stream
);
    import crcf_pkg::*;

    result_t [MAX_RESULTS-1:0] word_reg;
    result_t [MAX_RESULTS-1:0] word_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic                      pop;

    // The head word drives the output channel.
    assign stream.valid       = (count_reg != '0);
    assign stream.out_byte    = word_reg[0].out_byte;
    assign stream.frame_end   = word_reg[0].frame_end;
    assign stream.last_of_run = word_reg[0].last_of_run;
    assign stream.status      = word_reg[0].status;

    assign pop      = stream.valid & stream.ready;
    assign can_load = (count_reg == '0) || ((count_reg == COUNT_W'(1)) && pop);

    // Load a new burst, or shift the bank down by one word on a pop.
    always_comb
    begin
        word_next  = word_reg;
        count_next = count_reg;
        if (load)
        begin
            word_next  = burst.word;
            count_next = burst.count;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                word_next[i] = word_reg[i + 1];
            end
            count_next = count_reg - COUNT_W'(1);
        end
    end

    // Word count is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload words need no reset.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// ===== rtl/crc8_length_framer.sv =====
`timescale 1ns / 1ps
// The first result word of an input word is offered in the cycle after it is taken.
// One input word a cycle while each gives one result and the output is ready; a frame start
// gives three results and a final payload byte two, and the next word waits for their last.
// Reset (rst_n, asynchronous, active low) closes any frame, clears the CRC and empties the bank.
// Depends on crcf_pkg, crcf_item_if, crcf_stream_if, crcf_core and crcf_out_queue.
module crc8_length_framer
(
    input  logic          clk,
    input  logic          rst_n,
    crcf_item_if.sink     item,
    crcf_stream_if.source stream
);
    import crcf_pkg::*;

    logic   can_load;
    logic   load;
    burst_t burst;

    // Framing state and result generation.
    crcf_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .can_load (can_load),
        .load     (load),
        .burst    (burst)
    );

    // Result bank and output channel.
    crcf_out_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .burst    (burst),
        .can_load (can_load),
        .stream   (stream)
    );

    // Every accepted word gives at least one result, offered in the next cycle.
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (burst.count != '0))
        else $error("accepted word produced no result");

    a_load_offers: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> stream.valid)
        else $error("no result offered after an accepted word");

    // A result that is not the last of its run is followed by another.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (stream.valid && stream.ready && !stream.last_of_run) |=> stream.valid)
        else $error("run of results ended early");

    // The CRC byte closes the run of its word and carries no error.
    a_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (stream.valid && stream.frame_end) |->
            (stream.last_of_run && (stream.status == STATUS_OK)))
        else $error("frame end on a bad or non-final result");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for crc8_length_framer: a queue-fed driver offers start and payload
// words, and a frame predictor checks every output byte in order under varying back-pressure.
// Depends on crcf_pkg, crcf_item_if, crcf_stream_if and the framer RTL.
module testbench;

    import crcf_pkg::*;

    localparam int LIMIT_CYCLES  = 300000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HEAVY_PCT     = 82;
    localparam int LIGHT_PCT     = 13;
    localparam int PHASE_ITEMS   = 98;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [1:0]
    {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed
    {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [15:0] frame_len;
    } item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    crcf_item_if   item_ch ();
    crcf_stream_if stream_ch ();

    crc8_length_framer uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .stream (stream_ch)
    );

    // Words waiting to be offered, and framed bytes still to arrive
    item_t   item_backlog[$];
    result_t framed_bytes_due[$];

    // Predictor state, as after reset
    logic [7:0]        model_crc  = '0;
    logic [LEFT_W-1:0] model_left = '0;
    logic              model_open = 1'b0;

    idle_mode_t idle_mode   = IDLE_NONE;
    idle_mode_t phase_order[4] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    logic       hold_arm    = 1'b0;
    logic       hold_done   = 1'b0;
    int         hold_left   = 0;
    int         mismatches  = 0;
    int         cycle_count = 0;

    item_t   taken;
    item_t   offered;
    result_t seen;
    result_t wanted;

    always #1 clk = ~clk;

    // CRC-8 over one byte, polynomial 0x07, shifted out from the top bit.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8)
        begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic void queue_framed_byte(input logic [7:0] b, input logic fend,
                                              input logic last, input status_t st);
        result_t r;
        r.out_byte    = b;
        r.frame_end   = fend;
        r.last_of_run = last;
        r.status      = st;
        framed_bytes_due.push_back(r);
    endfunction

    // Works out the bytes that one accepted word causes and advances the frame state.
    function automatic void predict_framing(input item_t it);
        if (it.kind == KIND_START)
        begin
            model_crc = '0;
            if (it.frame_len == 16'd0 || it.frame_len > MAX_LEN)
            begin
                model_open = 1'b0;
                model_left = '0;
                queue_framed_byte(8'h00, 1'b0, 1'b1, STATUS_BAD_LEN);
            end
            else
            begin
                model_open = 1'b1;
                model_left = it.frame_len[LEFT_W-1:0];
                queue_framed_byte(START_BYTE, 1'b0, 1'b0, STATUS_OK);
                queue_framed_byte(it.frame_len[15:8], 1'b0, 1'b0, STATUS_OK);
                queue_framed_byte(it.frame_len[7:0], 1'b0, 1'b1, STATUS_OK);
            end
        end
        else if (!model_open)
        begin
            queue_framed_byte(8'h00, 1'b0, 1'b1, STATUS_NO_FRAME);
        end
        else
        begin
            model_crc = crc8_update(model_crc, it.data_byte);
            if (model_left != 0)
                model_left = model_left - 1'b1;
            if (model_left == 0)
            begin
                queue_framed_byte(it.data_byte, 1'b0, 1'b0, STATUS_OK);
                queue_framed_byte(model_crc, 1'b1, 1'b1, STATUS_OK);
                model_open = 1'b0;
                model_crc  = '0;
            end
            else
            begin
                queue_framed_byte(it.data_byte, 1'b0, 1'b1, STATUS_OK);
            end
        end
    endfunction

    function automatic logic sender_gap();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < HEAVY_PCT;
            IDLE_BOTH: return $urandom_range(99) < LIGHT_PCT;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stall();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99) < HEAVY_PCT;
            IDLE_BOTH: return $urandom_range(99) < LIGHT_PCT;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic void push_start(input int len);
        item_t it;
        it.kind      = KIND_START;
        it.data_byte = 8'($urandom_range(255));
        it.frame_len = 16'(len);
        item_backlog.push_back(it);
    endfunction

    function automatic void push_byte(input int b);
        item_t it;
        it.kind      = KIND_DATA;
        it.data_byte = 8'(b);
        it.frame_len = 16'($urandom_range(65535));
        item_backlog.push_back(it);
    endfunction

    // A start for len bytes followed by sent random payload bytes (fewer leaves it open).
    function automatic void push_frame(input int len, input int sent);
        push_start(len);
        for (int i = 0; i < sent; i++)
            push_byte($urandom_range(255));
    endfunction

    // Mostly complete frames of random content; the rest truncated frames, stray starts
    // with any length and stray payload bytes.
    task automatic fill_random(input int budget);
        int pushed;
        int pick;
        int len;
        int sent;
        pushed = 0;
        while (pushed < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
                push_frame(len, len);
                pushed += len + 1;
            end
            else if (pick < 87)
            begin
                len  = $urandom_range(40, 2);
                sent = $urandom_range(len - 1, 0);
                push_frame(len, sent);
                pushed += sent + 1;
            end
            else if (pick < 94)
            begin
                push_start($urandom_range(65535));
                pushed++;
            end
            else
            begin
                push_byte($urandom_range(255));
                pushed++;
            end
        end
    endtask

    task automatic drain_backlog();
        while (item_backlog.size() != 0 || item_ch.valid)
            @(negedge clk);
    endtask

    // Driver: records the accepted word, then offers the next one unless a gap is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                taken.kind      = kind_t'(item_ch.kind);
                taken.data_byte = item_ch.data_byte;
                taken.frame_len = item_ch.frame_len;
                predict_framing(taken);
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (item_backlog.size() != 0 && !sender_gap())
                begin
                    offered = item_backlog.pop_front();
                    item_ch.kind      <= offered.kind;
                    item_ch.data_byte <= offered.data_byte;
                    item_ch.frame_len <= offered.frame_len;
                    item_ch.valid     <= 1'b1;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, armed once, counted here.
    always @(posedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready.
    always @(posedge clk)
    begin
        if (rst_n)
            stream_ch.ready <= (hold_left == 0) && !receiver_stall();
    end

    // Monitor: each accepted output word against the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && stream_ch.valid && stream_ch.ready)
        begin
            seen.out_byte    = stream_ch.out_byte;
            seen.frame_end   = stream_ch.frame_end;
            seen.last_of_run = stream_ch.last_of_run;
            seen.status      = stream_ch.status;
            if (framed_bytes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected word: byte %02h end %b last %b status %0d",
                             $realtime, seen.out_byte, seen.frame_end, seen.last_of_run,
                             seen.status);
            end
            else
            begin
                wanted = framed_bytes_due.pop_front();
                if (seen.out_byte !== wanted.out_byte || seen.frame_end !== wanted.frame_end
                    || seen.last_of_run !== wanted.last_of_run
                    || seen.status !== wanted.status)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: mismatch: expected %02h %b %b %0d, got %02h %b %b %0d",
                                 $realtime, wanted.out_byte, wanted.frame_end,
                                 wanted.last_of_run, wanted.status, seen.out_byte,
                                 seen.frame_end, seen.last_of_run, seen.status);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("crc8_length_framer verification failed");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        item_ch.valid     = 1'b0;
        item_ch.kind      = KIND_START;
        item_ch.data_byte = 8'h00;
        item_ch.frame_len = 16'h0000;
        stream_ch.ready   = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: stray byte after reset, shortest frame, bad lengths, the largest frame
        // abandoned by a new start, a frame cut short by a bad length, then a fresh frame.
        push_byte(8'h5A);
        push_start(1);
        push_byte(8'hFF);
        push_start(0);
        push_start(MAX_FRAME + 1);
        push_start(16'hFFFF);
        push_start(MAX_FRAME);
        push_byte(8'h00);
        push_byte(8'h80);
        push_start(2);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_start(3);
        push_byte(8'h01);
        push_start(0);
        push_byte(8'hAA);
        push_start(16'h02AA);
        push_byte(8'h55);
        push_start(1);
        push_byte(8'h00);
        drain_backlog();

        // Random phases, one per idling pattern; the long hold-off falls in the first.
        foreach (phase_order[p])
        begin
            idle_mode = phase_order[p];
            if (phase_order[p] == IDLE_NONE)
                hold_arm = 1'b1;
            fill_random(PHASE_ITEMS);
            drain_backlog();
        end

        while (framed_bytes_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("crc8_length_framer verification clean");
        else
            $display("crc8_length_framer verification failed");
        $finish;
    end

endmodule
